### src/esd_pkg.sv
`default_nettype none

package esd_pkg;

  // field widths
  localparam int unsigned CODE_W         = 21;
  localparam int unsigned CHAR_W         = 32;
  localparam int unsigned LENGTH_W       = 21;
  localparam int unsigned CAPACITY_W     = 20;
  localparam int unsigned DIGITS_W       = 4;
  localparam int unsigned COUNT_W_DEFAULT = 21;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = CAPACITY_W'(1024);

  // character codes
  localparam logic [CODE_W-1:0] ASCII_MAX    = CODE_W'(8'h7f);
  localparam logic [CODE_W-1:0] CH_BACKSLASH = CODE_W'(8'h5c);
  localparam logic [CODE_W-1:0] CH_SQUOTE    = CODE_W'(8'h27);
  localparam logic [CODE_W-1:0] CH_DQUOTE    = CODE_W'(8'h22);
  localparam logic [CODE_W-1:0] CH_QUESTION  = CODE_W'(8'h3f);
  localparam logic [CODE_W-1:0] CH_LOWER_A   = CODE_W'(8'h61);
  localparam logic [CODE_W-1:0] CH_LOWER_B   = CODE_W'(8'h62);
  localparam logic [CODE_W-1:0] CH_LOWER_F   = CODE_W'(8'h66);
  localparam logic [CODE_W-1:0] CH_LOWER_N   = CODE_W'(8'h6e);
  localparam logic [CODE_W-1:0] CH_LOWER_R   = CODE_W'(8'h72);
  localparam logic [CODE_W-1:0] CH_LOWER_T   = CODE_W'(8'h74);
  localparam logic [CODE_W-1:0] CH_LOWER_V   = CODE_W'(8'h76);
  localparam logic [CODE_W-1:0] CH_LOWER_X   = CODE_W'(8'h78);
  localparam logic [CODE_W-1:0] CH_LOWER_U   = CODE_W'(8'h75);
  localparam logic [CODE_W-1:0] CH_UPPER_U   = CODE_W'(8'h55);
  localparam logic [CODE_W-1:0] CH_DIGIT_0   = CODE_W'(8'h30);
  localparam logic [CODE_W-1:0] CH_DIGIT_9   = CODE_W'(8'h39);
  localparam logic [CODE_W-1:0] CH_UPPER_A   = CODE_W'(8'h41);
  localparam logic [CODE_W-1:0] CH_UPPER_F   = CODE_W'(8'h46);

  // values the simple escapes stand for
  localparam logic [CHAR_W-1:0] VAL_BELL      = CHAR_W'(7);
  localparam logic [CHAR_W-1:0] VAL_BACKSPACE = CHAR_W'(8);
  localparam logic [CHAR_W-1:0] VAL_TAB       = CHAR_W'(9);
  localparam logic [CHAR_W-1:0] VAL_NEWLINE   = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] VAL_VTAB      = CHAR_W'(11);
  localparam logic [CHAR_W-1:0] VAL_FORMFEED  = CHAR_W'(12);
  localparam logic [CHAR_W-1:0] VAL_RETURN    = CHAR_W'(13);

  localparam logic [DIGITS_W-1:0] DIGITS_X       = DIGITS_W'(2);
  localparam logic [DIGITS_W-1:0] DIGITS_U_SHORT = DIGITS_W'(4);
  localparam logic [DIGITS_W-1:0] DIGITS_U_LONG  = DIGITS_W'(8);
  localparam logic [3:0]          HEX_LETTER_OFFSET = 4'd10;

  typedef enum logic [1:0] {
    PHASE_PLAIN  = 2'd0,
    PHASE_ESCAPE = 2'd1,
    PHASE_HEX    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK             = 2'd0,
    STATUS_UNKNOWN_ESCAPE = 2'd1,
    STATUS_NO_STORAGE     = 2'd2
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    logic              last_char;
  } char_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0]   out_char;
    logic                out_valid;
    logic                string_done;
    status_t             status;
    logic [LENGTH_W-1:0] total_length;
  } result_word_t;

  // value of one hex digit, zero for anything that is not one
  function automatic logic [3:0] hex_value(input logic [CODE_W-1:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
      v = 4'(c - CH_DIGIT_0);
    end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
      v = 4'(c - CH_UPPER_A) + HEX_LETTER_OFFSET;
    end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
      v = 4'(c - CH_LOWER_A) + HEX_LETTER_OFFSET;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### src/escape_sequence_decoder.sv
`default_nettype none

// channel  direction  handshake                 word
// char     in         char_valid / char_ready   char_word     (code_point, last_char)
// result   out        result_valid / result_ready  result_word (one per char word)
// cfg      in         cfg_valid / cfg_ready     cfg_data      (max_out_length)
//
// one char word a cycle while char_ready is high; each result is registered on the edge that accepts its char word
// the escape state update and the result are computed in a single pass per word
// a new char word is taken when no result is held, or while the held result is being taken on the same edge
// rst (synchronous) clears the escape state and sets the capacity to 1024
// cfg_ready is always high

module escape_sequence_decoder #(
  parameter int unsigned COUNT_WIDTH = esd_pkg::COUNT_W_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               char_valid,
  output logic                              char_ready,
  input  wire esd_pkg::char_word_t          char_word,
  output logic                              result_valid,
  input  wire                               result_ready,
  output esd_pkg::result_word_t             result_word,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [esd_pkg::CAPACITY_W-1:0]     cfg_data
);

  import esd_pkg::*;

  // width for the end-of-string capacity compare
  localparam int unsigned CMP_W = (COUNT_WIDTH > CAPACITY_W) ? COUNT_WIDTH : CAPACITY_W;

  // string state
  phase_t                  phase, phase_next;
  logic [DIGITS_W-1:0]     digits_left, digits_left_next;
  logic [CHAR_W-1:0]       accumulator, accumulator_next;
  logic [COUNT_WIDTH-1:0]  count, count_next;
  logic                    error_seen, error_seen_next;

  logic [CAPACITY_W-1:0]   max_out_length;

  result_word_t            result_next;
  logic                    accept;
  logic                    emit;
  logic [CHAR_W-1:0]       ch;
  logic [CODE_W-1:0]       c;

  // the result register frees up when empty or being taken
  assign char_ready = !result_valid || result_ready;
  assign accept     = char_valid && char_ready;
  assign cfg_ready  = 1'b1;
  assign c          = char_word.code_point;

  always_comb begin
    phase_next       = phase;
    digits_left_next = digits_left;
    accumulator_next = accumulator;
    error_seen_next  = error_seen;
    emit             = 1'b0;
    ch               = '0;

    if (!error_seen) begin
      if ((phase == PHASE_ESCAPE || phase == PHASE_HEX) && c > ASCII_MAX) begin
        // non-ascii inside an escape
        error_seen_next = 1'b1;
      end else begin
        case (phase)
          PHASE_ESCAPE: begin
            phase_next = PHASE_PLAIN;
            emit       = 1'b1;
            case (c)
              CH_BACKSLASH, CH_SQUOTE, CH_DQUOTE, CH_QUESTION: ch = CHAR_W'(c);
              CH_LOWER_A: ch = VAL_BELL;
              CH_LOWER_B: ch = VAL_BACKSPACE;
              CH_LOWER_F: ch = VAL_FORMFEED;
              CH_LOWER_N: ch = VAL_NEWLINE;
              CH_LOWER_R: ch = VAL_RETURN;
              CH_LOWER_T: ch = VAL_TAB;
              CH_LOWER_V: ch = VAL_VTAB;
              CH_LOWER_X, CH_LOWER_U, CH_UPPER_U: begin
                emit             = 1'b0;
                phase_next       = PHASE_HEX;
                accumulator_next = '0;
                digits_left_next = (c == CH_LOWER_X) ? DIGITS_X :
                                   (c == CH_LOWER_U) ? DIGITS_U_SHORT : DIGITS_U_LONG;
              end
              default: begin
                // unknown escape letter
                emit            = 1'b0;
                error_seen_next = 1'b1;
              end
            endcase
          end
          PHASE_HEX: begin
            // a bad digit still takes a position, as zero; wraps at 32 bits
            accumulator_next = {accumulator[CHAR_W-5:0], hex_value(c)};
            if (digits_left != '0) begin
              digits_left_next = digits_left - DIGITS_W'(1);
            end
            if (digits_left_next == '0) begin
              phase_next = PHASE_PLAIN;
              ch         = accumulator_next;
              emit       = 1'b1;
            end
          end
          default: begin
            // plain text
            phase_next = PHASE_PLAIN;
            if (c == CH_BACKSLASH) begin
              phase_next = PHASE_ESCAPE;
            end else begin
              ch   = CHAR_W'(c);
              emit = 1'b1;
            end
          end
        endcase
      end
    end

    // saturating character count
    count_next = count;
    if (emit && count != '1) begin
      count_next = count + COUNT_WIDTH'(1);
    end

    result_next.out_char     = emit ? ch : '0;
    result_next.out_valid    = emit;
    result_next.string_done  = char_word.last_char;
    result_next.status       = STATUS_OK;
    result_next.total_length = '0;

    if (char_word.last_char) begin
      if (error_seen_next) begin
        result_next.status = STATUS_UNKNOWN_ESCAPE;
      end else if (CMP_W'(count_next) < CMP_W'(max_out_length)) begin
        result_next.total_length = LENGTH_W'(count_next);
      end else begin
        result_next.status = STATUS_NO_STORAGE;
      end
      // back to a clean state for the next string; an open escape is dropped
      phase_next       = PHASE_PLAIN;
      digits_left_next = '0;
      accumulator_next = '0;
      count_next       = '0;
      error_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PHASE_PLAIN;
      digits_left <= '0;
      accumulator <= '0;
      count       <= '0;
      error_seen  <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      digits_left <= digits_left_next;
      accumulator <= accumulator_next;
      count       <= count_next;
      error_seen  <= error_seen_next;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_length <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_out_length <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_word <= result_next;
    end
  end

endmodule

`default_nettype wire
